FILE: hdl/arp_cache_responder_core_macros.svh
// Assertion macros for the ARP cache and responder.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef ARP_CACHE_RESPONDER_CORE_MACROS_SVH
`define ARP_CACHE_RESPONDER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ARPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ARPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/arpc_pkg.sv
// Shared types and constants for the ARP cache and responder.
// No dependencies; used by every module of the block.
package arpc_pkg;

    // Table size and derived widths
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // ARP header constants
    localparam logic [10:0] MIN_FRAME_LEN = 11'd28;
    localparam logic [15:0] HW_ETHERNET   = 16'h0001;
    localparam logic [15:0] PROTO_IPV4    = 16'h0800;
    localparam logic [15:0] OP_REQUEST    = 16'h0001;

    // Command codes
    localparam logic CMD_RX_PACKET = 1'b0;
    localparam logic CMD_LOOKUP    = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_HIT   = 2'd2;
    localparam logic [1:0] KIND_MISS  = 2'd3;

    localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

    // Register file
    localparam int          APB_ADDR_W = 4;
    localparam logic        REG_OWN_MAC = 1'b0;
    localparam logic        REG_OWN_IP  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [10:0] frame_len;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [15:0] arp_opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip_in;
        logic [31:0] query_ip;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [47:0] dest_mac;
        logic [47:0] target_mac;
        logic [31:0] target_ip;
        logic [47:0] found_mac;
        logic        learned;
    } out_item_t;

    // Table write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [31:0]      ip;
        logic [47:0]      mac;
    } tbl_wr_t;

    // Table read request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } tbl_rd_t;

    // Own addresses from the register file
    typedef struct packed {
        logic [47:0] own_mac;
        logic [31:0] own_ip;
    } own_cfg_t;

    // Sequencer status
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] entry_count;
    } ctrl_stat_t;

endpackage

FILE: hdl/arp_cache_responder_core.sv
// ARP cache and responder top level: register file, output register, assertions.
// Depends on arpc_pkg, arpc_table, arpc_ctrl and the assertion macro header.
`include "arp_cache_responder_core_macros.svh"

// Takes one beat at a time: a parsed received ARP packet or a lookup request,
// and returns exactly one result beat for each. Well-formed packets addressed to
// own_ip (or gratuitous) are learned into a 64-entry cache with FIFO
// replacement; requests to us also produce a reply. Lookups report a hit or
// ask for a broadcast request. A dropped packet skips the table scan; a miss or
// a newly learned address scans all entry_count entries, and a hit or a refresh
// at entry i stops there. The scan is linear, through the single table read
// port and one shared comparator. The result sits in an output register, so
// the next beat is taken while it waits; a further result stalls only if that
// register has still not drained. own_mac and own_ip are written over APB
// (0x0 and 0x8); the user must write them only while the block idles, as the
// block itself has no guard for it.
module arp_cache_responder_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [arpc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [63:0]                       pwdata,
    output logic [63:0]                       prdata,
    output logic                              pready,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  arpc_pkg::in_item_t                s_data,
    // result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output arpc_pkg::out_item_t               m_data
);
    import arpc_pkg::*;

    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    own_cfg_t    cfg;
    tbl_wr_t     tbl_wr;
    tbl_rd_t     tbl_rd;
    logic [31:0] tbl_rd_ip;
    logic [47:0] tbl_rd_mac;
    logic        res_vld;
    logic        res_rdy;
    out_item_t   res;
    ctrl_stat_t  stat;
    logic        cfg_wr;
    logic        in_beat;
    logic        out_hit;
    logic        out_other;
    logic        send_clr;

    // register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end else if (cfg_wr) begin
            case (paddr[3])
                REG_OWN_MAC: own_mac_reg <= pwdata[47:0];
                REG_OWN_IP:  own_ip_reg  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_OWN_MAC: prdata = {16'd0, own_mac_reg};
            REG_OWN_IP:  prdata = {32'd0, own_ip_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg.own_mac = own_mac_reg;
    assign cfg.own_ip  = own_ip_reg;

    arpc_table u_table (
        .aclk   (aclk),
        .wr     (tbl_wr),
        .rd     (tbl_rd),
        .rd_ip  (tbl_rd_ip),
        .rd_mac (tbl_rd_mac)
    );

    arpc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_vld     (s_valid),
        .in_rdy     (s_ready),
        .in_item    (s_data),
        .res_vld    (res_vld),
        .res_rdy    (res_rdy),
        .res        (res),
        .tbl_wr     (tbl_wr),
        .tbl_rd     (tbl_rd),
        .tbl_rd_ip  (tbl_rd_ip),
        .tbl_rd_mac (tbl_rd_mac),
        .stat       (stat)
    );

    // output register, free when empty or being drained
    assign res_rdy = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_vld && res_rdy) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_vld && res_rdy) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    assign in_beat   = s_valid && s_ready;
    assign out_hit   = m_valid && (m_data.result_kind == KIND_HIT);
    assign out_other = m_valid && (m_data.result_kind != KIND_HIT);
    assign send_clr  = (m_data.dest_mac == '0) && (m_data.target_ip == '0) &&
                       !m_data.learned;

    `ARPC_ASSERT_NXT(a_busy_after_accept, in_beat, !s_ready && stat.busy, "ready after accept")
    `ARPC_ASSERT_IMP(a_count_bound, 1'b1, stat.entry_count <= CNT_W'(TABLE_ENTRIES), "count over")
    `ARPC_ASSERT_IMP(a_found_only_hit, out_other, m_data.found_mac == '0, "found_mac without hit")
    `ARPC_ASSERT_IMP(a_hit_no_send, out_hit, send_clr, "hit carries send fields")

endmodule

FILE: hdl/arpc_table.sv
// Cache storage: IP and MAC per entry, one write and one registered read port.
// Depends on arpc_pkg.
module arpc_table (
    input  logic             aclk,
    input  arpc_pkg::tbl_wr_t wr,
    input  arpc_pkg::tbl_rd_t rd,
    output logic [31:0]      rd_ip,
    output logic [47:0]      rd_mac
);
    import arpc_pkg::*;

    logic [31:0] ip_mem  [TABLE_ENTRIES];
    logic [47:0] mac_mem [TABLE_ENTRIES];
    logic [31:0] rd_ip_reg;
    logic [47:0] rd_mac_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            ip_mem[wr.addr]  <= wr.ip;
            mac_mem[wr.addr] <= wr.mac;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_ip_reg  <= ip_mem[rd.addr];
            rd_mac_reg <= mac_mem[rd.addr];
        end
    end

    assign rd_ip  = rd_ip_reg;
    assign rd_mac = rd_mac_reg;

endmodule

FILE: hdl/arpc_ctrl.sv
// Sequencer: packet checks, linear table scan through one shared comparator,
// learning and result assembly. Depends on arpc_pkg.
module arpc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  arpc_pkg::own_cfg_t    cfg,
    input  logic                  in_vld,
    output logic                  in_rdy,
    input  arpc_pkg::in_item_t    in_item,
    output logic                  res_vld,
    input  logic                  res_rdy,
    output arpc_pkg::out_item_t   res,
    output arpc_pkg::tbl_wr_t     tbl_wr,
    output arpc_pkg::tbl_rd_t     tbl_rd,
    input  logic [31:0]           tbl_rd_ip,
    input  logic [47:0]           tbl_rd_mac,
    output arpc_pkg::ctrl_stat_t  stat
);
    import arpc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    logic [1:0]       state_reg,    state_next;
    in_item_t         item_reg,     item_next;
    logic [31:0]      key_reg,      key_next;
    logic             learn_reg,    learn_next;
    logic             reply_reg,    reply_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic [IDX_W-1:0] ins_pos_reg,  ins_pos_next;
    out_item_t        res_reg,      res_next;

    logic pkt_ok;
    logic for_us;
    logic gratuitous;
    logic rd_more;
    logic match;

    assign pkt_ok = (item_reg.frame_len >= MIN_FRAME_LEN) &&
                    (item_reg.hw_type == HW_ETHERNET) &&
                    (item_reg.proto_type == PROTO_IPV4);
    assign for_us     = (item_reg.target_ip_in == cfg.own_ip);
    assign gratuitous = (item_reg.sender_ip == item_reg.target_ip_in);

    // shared comparator on the entry read last cycle
    assign rd_more = (scan_idx_reg < count_reg);
    assign match   = pend_vld_reg && (tbl_rd_ip == key_reg);

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        key_next      = key_reg;
        learn_next    = learn_reg;
        reply_next    = reply_reg;
        scan_idx_next = scan_idx_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        count_next    = count_reg;
        ins_pos_next  = ins_pos_reg;
        res_next      = res_reg;
        tbl_wr        = '0;
        tbl_rd        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_vld) begin
                    item_next  = in_item;
                    state_next = ST_CHECK;
                end
            end

            // decide between lookup, learn or drop
            ST_CHECK: begin
                scan_idx_next = '0;
                pend_vld_next = 1'b0;
                res_next      = '0;
                reply_next    = for_us && (item_reg.arp_opcode == OP_REQUEST);
                if (item_reg.cmd == CMD_LOOKUP) begin
                    key_next   = item_reg.query_ip;
                    learn_next = 1'b0;
                    state_next = ST_SCAN;
                end else if (pkt_ok && (for_us || gratuitous)) begin
                    key_next   = item_reg.sender_ip;
                    learn_next = 1'b1;
                    state_next = ST_SCAN;
                end else begin
                    res_next.result_kind = KIND_NONE;
                    state_next           = ST_EMIT;
                end
            end

            // one entry read per cycle, compared in the next cycle
            ST_SCAN: begin
                if (match || (!rd_more && !pend_vld_reg)) begin
                    pend_vld_next = 1'b0;
                    state_next    = ST_EMIT;
                    res_next      = '0;
                    if (learn_reg) begin
                        tbl_wr.en  = 1'b1;
                        tbl_wr.ip  = key_reg;
                        tbl_wr.mac = item_reg.sender_mac;
                        if (match) begin
                            tbl_wr.addr = pend_idx_reg;
                        end else begin
                            tbl_wr.addr  = ins_pos_reg;
                            ins_pos_next = (ins_pos_reg == IDX_LAST) ? '0
                                         : ins_pos_reg + 1'b1;
                            if (count_reg < CNT_FULL) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        res_next.learned = 1'b1;
                        if (reply_reg) begin
                            res_next.result_kind = KIND_REPLY;
                            res_next.dest_mac    = item_reg.sender_mac;
                            res_next.target_mac  = item_reg.sender_mac;
                            res_next.target_ip   = item_reg.sender_ip;
                        end else begin
                            res_next.result_kind = KIND_NONE;
                        end
                    end else if (match) begin
                        res_next.result_kind = KIND_HIT;
                        res_next.found_mac   = tbl_rd_mac;
                    end else begin
                        res_next.result_kind = KIND_MISS;
                        res_next.dest_mac    = MAC_BROADCAST;
                        res_next.target_ip   = key_reg;
                    end
                end else begin
                    tbl_rd.en     = rd_more;
                    tbl_rd.addr   = scan_idx_reg[IDX_W-1:0];
                    pend_vld_next = rd_more;
                    pend_idx_next = scan_idx_reg[IDX_W-1:0];
                    if (rd_more) begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end

            // hand the result to the output register
            ST_EMIT: begin
                if (res_rdy) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ins_pos_reg  <= '0;
            pend_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ins_pos_reg  <= ins_pos_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    // payload and scan working registers
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        key_reg      <= key_next;
        learn_reg    <= learn_next;
        reply_reg    <= reply_next;
        scan_idx_reg <= scan_idx_next;
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
    end

    assign in_rdy           = (state_reg == ST_IDLE);
    assign res_vld          = (state_reg == ST_EMIT);
    assign res              = res_reg;
    assign stat.busy        = (state_reg != ST_IDLE);
    assign stat.entry_count = count_reg;

endmodule

FILE: tb/tb_arp_cache_responder_core.sv
// Self-checking testbench for arp_cache_responder_core: directed and random ARP
// traffic, APB set-up of own_mac/own_ip, random stalls on both channels.
// Depends on arpc_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_arp_cache_responder_core;
    import arpc_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_OWN_MAC = {REG_OWN_MAC, 3'b000};
    localparam logic [APB_ADDR_W-1:0] ADDR_OWN_IP  = {REG_OWN_IP, 3'b000};
    localparam logic [15:0]           OP_REPLY     = 16'h0002;
    localparam int                    POOL_SIZE    = 96;
    localparam int                    HOLD_CYCLES  = 400;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [63:0]           pwdata  = '0;
    logic [63:0]           prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;

    // Predictor state: cache contents and own addresses
    logic [31:0] cache_ip  [TABLE_ENTRIES];
    logic [47:0] cache_mac [TABLE_ENTRIES];
    int          cache_fill   = 0;
    int          cache_wr_pos = 0;
    logic [47:0] cfg_mac      = '0;
    logic [31:0] cfg_ip       = '0;

    out_item_t   pending_results[$];
    logic [31:0] ip_pool [POOL_SIZE];
    int          errors        = 0;
    logic        idle_en       = 1'b1;
    int          hold_requests = 0;
    int          hold_done     = 0;
    int          rx_stall_left = 0;

    always #2 aclk = ~aclk;

    arp_cache_responder_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ---------------------------------------------------------------- predictor

    // First valid entry holding ip, or -1
    function automatic int cache_find(logic [31:0] ip);
        for (int i = 0; i < cache_fill; i++) begin
            if (cache_ip[i] == ip) return i;
        end
        return -1;
    endfunction

    // Refresh a known IP, else insert at the FIFO position
    function automatic void cache_learn(logic [47:0] mac, logic [31:0] ip);
        int idx;
        idx = cache_find(ip);
        if (idx >= 0) begin
            cache_mac[idx] = mac;
            return;
        end
        cache_ip[cache_wr_pos]  = ip;
        cache_mac[cache_wr_pos] = mac;
        cache_wr_pos = (cache_wr_pos + 1) % TABLE_ENTRIES;
        if (cache_fill < TABLE_ENTRIES) cache_fill++;
    endfunction

    // Expected result beat for one accepted input beat; updates the cache
    function automatic out_item_t resolve_arp(in_item_t b);
        out_item_t r;
        int        idx;
        r = '0;
        if (b.cmd == CMD_LOOKUP) begin
            idx = cache_find(b.query_ip);
            if (idx >= 0) begin
                r.result_kind = KIND_HIT;
                r.found_mac   = cache_mac[idx];
            end else begin
                r.result_kind = KIND_MISS;
                r.dest_mac    = MAC_BROADCAST;
                r.target_ip   = b.query_ip;
            end
        end else if (b.frame_len >= MIN_FRAME_LEN && b.hw_type == HW_ETHERNET &&
                     b.proto_type == PROTO_IPV4) begin
            if (b.target_ip_in == cfg_ip || b.sender_ip == b.target_ip_in) begin
                // reply only to requests aimed at us; gratuitous is learned only
                if (b.target_ip_in == cfg_ip && b.arp_opcode == OP_REQUEST) begin
                    r.result_kind = KIND_REPLY;
                    r.dest_mac    = b.sender_mac;
                    r.target_mac  = b.sender_mac;
                    r.target_ip   = b.sender_ip;
                end
                cache_learn(b.sender_mac, b.sender_ip);
                r.learned = 1'b1;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string fname, logic [47:0] want, logic [47:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            errors++;
        end
    endfunction

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %p", $time, m_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", 48'(want.result_kind), 48'(m_data.result_kind));
                check_field("dest_mac",    want.dest_mac,         m_data.dest_mac);
                check_field("target_mac",  want.target_mac,       m_data.target_mac);
                check_field("target_ip",   48'(want.target_ip),   48'(m_data.target_ip));
                check_field("found_mac",   want.found_mac,        m_data.found_mac);
                check_field("learned",     48'(want.learned),     48'(m_data.learned));
            end
        end
    end

    // Result receiver: random stall bursts, plus a long hold on request
    always @(posedge aclk) begin
        if (hold_done != hold_requests) begin
            hold_done     <= hold_requests;
            rx_stall_left <= HOLD_CYCLES;
            m_ready       <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_ready       <= 1'b0;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            rx_stall_left <= $urandom_range(0, 6);
            m_ready       <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Only while the block idles
    task automatic set_own_addr(input logic [47:0] mac, input logic [31:0] ip);
        apb_write(ADDR_OWN_MAC, {16'h0, mac});
        apb_write(ADDR_OWN_IP, {32'h0, ip});
        cfg_mac = mac;
        cfg_ip  = ip;
    endtask

    // Offer one beat; valid stays up after acceptance so back-to-back beats
    // need no extra edge. Prediction is taken at the accepting edge.
    task automatic send_beat(input in_item_t beat);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(resolve_arp(beat));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic in_item_t arp_pkt(logic [15:0] op, logic [47:0] smac,
                                         logic [31:0] sip, logic [31:0] tip);
        in_item_t b;
        b            = '0;
        b.cmd        = CMD_RX_PACKET;
        b.frame_len  = 11'd60;
        b.hw_type    = HW_ETHERNET;
        b.proto_type = PROTO_IPV4;
        b.arp_opcode = op;
        b.sender_mac = smac;
        b.sender_ip  = sip;
        b.target_ip_in = tip;
        b.query_ip   = $urandom;
        return b;
    endfunction

    function automatic in_item_t lookup_beat(logic [31:0] ip);
        in_item_t b;
        b          = '0;
        b.cmd      = CMD_LOOKUP;
        b.query_ip = ip;
        return b;
    endfunction

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly pool addresses so refreshes and hits happen
    function automatic logic [31:0] pick_ip();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return cfg_ip;
        if (sel == 1) return $urandom;
        return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic in_item_t random_arp_beat();
        in_item_t    b;
        int unsigned sel;
        b = arp_pkt($urandom_range(0, 1) ? OP_REQUEST : OP_REPLY, rand_mac(), pick_ip(), cfg_ip);
        b.frame_len = 11'($urandom_range(MIN_FRAME_LEN, 2047));
        if ($urandom_range(0, 4) == 0) b.arp_opcode = 16'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            // lookup with junk in the packet fields
            b            = lookup_beat(pick_ip());
            b.frame_len  = 11'($urandom);
            b.hw_type    = 16'($urandom);
            b.proto_type = 16'($urandom);
            b.arp_opcode = 16'($urandom);
            b.sender_mac = rand_mac();
            b.sender_ip  = $urandom;
            b.target_ip_in = $urandom;
        end else if (sel < 55) begin
            // well-formed, addressed to us
        end else if (sel < 65) begin
            b.target_ip_in = b.sender_ip;
        end else if (sel < 75) begin
            b.target_ip_in = $urandom;
        end else if (sel < 80) begin
            b.frame_len = 11'($urandom_range(0, MIN_FRAME_LEN - 1));
        end else if (sel < 85) begin
            b.hw_type = 16'($urandom);
        end else if (sel < 90) begin
            b.proto_type = 16'($urandom);
        end else begin
            b = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        end
        return b;
    endfunction

    // ---------------------------------------------------------------- tests

    // Register write and read-back at both extremes
    task automatic test_config_regs();
        logic [63:0] rd;
        set_own_addr('0, '0);
        apb_read(ADDR_OWN_MAC, rd);
        check_field("own_mac readback", cfg_mac, rd[47:0]);
        apb_read(ADDR_OWN_IP, rd);
        check_field("own_ip readback", 48'(cfg_ip), 48'(rd[31:0]));
        set_own_addr('1, '1);
        apb_read(ADDR_OWN_MAC, rd);
        check_field("own_mac readback", cfg_mac, rd[47:0]);
        apb_read(ADDR_OWN_IP, rd);
        check_field("own_ip readback", 48'(cfg_ip), 48'(rd[31:0]));
    endtask

    // Field extremes, drops, opcodes, gratuitous, hits, misses, refresh
    task automatic test_directed();
        in_item_t    b;
        logic [31:0] ip_a, ip_b, ip_c;
        ip_a = 32'hC0A8_0A10;
        ip_b = 32'h0000_0000;
        ip_c = 32'hFFFF_FFFE;
        set_own_addr(48'h0200_5E10_2030, 32'hC0A8_0A01);
        send_beat(lookup_beat(32'h0));                       // miss on empty cache
        send_beat(lookup_beat(32'hFFFF_FFFF));
        b = arp_pkt(OP_REQUEST, rand_mac(), ip_a, cfg_ip);
        b.frame_len = MIN_FRAME_LEN - 11'd1;                 // short
        send_beat(b);
        b.frame_len = 11'd0;
        send_beat(b);
        b.frame_len = MIN_FRAME_LEN;                         // shortest legal: reply
        b.sender_mac = '1;
        send_beat(b);
        b = arp_pkt(OP_REPLY, '0, ip_b, cfg_ip);
        b.frame_len = 11'h7FF;
        send_beat(b);
        b = arp_pkt(OP_REQUEST, rand_mac(), ip_c, cfg_ip);
        b.hw_type = 16'h0000;                                // foreign hardware
        send_beat(b);
        b.hw_type = 16'hFFFF;
        send_beat(b);
        b.hw_type = HW_ETHERNET;
        b.proto_type = 16'h0806;                             // foreign protocol
        send_beat(b);
        b.proto_type = 16'hFFFF;
        send_beat(b);
        send_beat(arp_pkt(16'h0000, rand_mac(), ip_c, cfg_ip));  // other opcode: learn only
        send_beat(arp_pkt(16'hFFFF, rand_mac(), 32'h0A00_0001, cfg_ip));
        send_beat(arp_pkt(OP_REQUEST, rand_mac(), 32'h0A00_0002, 32'h0A00_0003));  // not for us
        send_beat(arp_pkt(OP_REQUEST, rand_mac(), 32'h0A00_0004, 32'h0A00_0004));  // gratuitous
        send_beat(arp_pkt(OP_REQUEST, rand_mac(), cfg_ip, cfg_ip));  // gratuitous to us
        send_beat(lookup_beat(ip_a));
        send_beat(lookup_beat(ip_b));
        send_beat(lookup_beat(ip_c));
        send_beat(arp_pkt(OP_REQUEST, 48'h1234_5678_9ABC, ip_a, cfg_ip));  // refresh
        send_beat(lookup_beat(ip_a));
        b = lookup_beat(32'h0A00_0004);
        b[$bits(in_item_t)-2:32] = '1;                       // junk in ignored fields
        send_beat(b);
        wait_drained();
    endtask

    // Over-fill the cache so the oldest insertions are replaced
    task automatic test_cache_wrap();
        for (int k = 0; k < TABLE_ENTRIES + 6; k++) begin
            send_beat(arp_pkt(OP_REPLY, rand_mac(), 32'h0A10_0000 + k, 32'h0A10_0000 + k));
        end
        send_beat(arp_pkt(OP_REPLY, rand_mac(), 32'h0A10_000A, 32'h0A10_000A));
        for (int k = 0; k < 8; k++) send_beat(lookup_beat(32'h0A10_0000 + k));
        send_beat(lookup_beat(32'h0A10_000A));
        send_beat(lookup_beat(32'h0A10_0000 + TABLE_ENTRIES + 5));
        wait_drained();
    endtask

    // Long receiver hold while beats keep coming, so the input stalls
    task automatic test_backpressure();
        hold_requests++;
        repeat (8) send_beat(random_arp_beat());
        wait_drained();
    endtask

    task automatic test_random(input logic [47:0] mac, input logic [31:0] ip, input int count);
        set_own_addr(mac, ip);
        repeat (count) send_beat(random_arp_beat());
        wait_drained();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        for (int k = 0; k < POOL_SIZE; k++) ip_pool[k] = $urandom;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_config_regs();
        test_directed();
        test_cache_wrap();
        test_backpressure();
        test_random('0, '0, 120);
        test_random('1, '1, 120);
        test_random(rand_mac(), $urandom, 120);
        test_random(rand_mac(), ip_pool[0], 120);
        // last stretch without idling on either side
        idle_en = 1'b0;
        test_random(rand_mac(), $urandom, 60);
        repeat (80) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #2_000_000;
        $display("%0t: run timed out, %0d results outstanding", $time, pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/arpc_pkg.sv
hdl/arpc_table.sv
hdl/arpc_ctrl.sv
hdl/arp_cache_responder_core.sv
tb/tb_arp_cache_responder_core.sv
